// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: shared types, constants and codes for the text console writer.
// No dependencies; tcw_in_if, tcw_out_if and text_console_writer import it.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int DEPTH   = ROWS * COLUMNS;

  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CELL_W  = 16;

  localparam int TAB_STEP = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOUR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR = 1'b1;

  localparam logic [3:0] RESET_FORE = 4'd7;
  localparam logic [3:0] RESET_BACK = 4'd0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_GLYPH = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  function automatic logic [CELL_W-1:0] make_cell(logic [7:0] ch, logic [3:0] fg,
                                                  logic [3:0] bg);
    return {bg, fg, ch};
  endfunction

endpackage

// ===== rtl/tcw_in_if.sv =====
// tcw_in_if: input channel of the text console writer (one word per character, cell read or clear).
// Depends on tcw_pkg.
`timescale 1ns / 1ps

interface tcw_in_if;
  import tcw_pkg::*;

  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] char_code;
  logic [3:0] char_fore;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, kind, char_code, char_fore, read_row, read_col,
                  input ready);
  modport sink   (input valid, kind, char_code, char_fore, read_row, read_col,
                  output ready);
endinterface

// ===== rtl/tcw_out_if.sv =====
// tcw_out_if: result channel of the text console writer (one word per input word).
// Depends on tcw_pkg.
`timescale 1ns / 1ps

interface tcw_out_if;
  import tcw_pkg::*;

  logic        valid;
  logic        ready;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [15:0] cell_value;
  logic        scrolled;

  modport source (output valid, cursor_row, cursor_col, cell_value, scrolled,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_value, scrolled,
                  output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
// tcw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/text_console_writer.sv =====
// text_console_writer: text-mode console, cell store in one RAM plus cursor.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if and tcw_ram.
//
//   channel     dir   handshake              word
//   char_in     in    valid/ready            kind, char_code, char_fore, read_row, read_col
//   result_out  out   valid/ready            cursor_row, cursor_col, cell_value, scrolled
//   cfg_*       in    cfg_write (no wait)    cfg_index, cfg_data
//
// A write or cursor move passes ST_EXEC and ST_DONE before its result is registered; an
// in-range cell read also passes ST_READ (registered RAM read data). A new word is taken after ST_DONE.
// A scroll rotates a top-row pointer and blanks the new bottom row in ST_BLANK.
// A clear screen sweeps the whole RAM, one cell a cycle.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with char_in.ready low.
// The result register lets the next word in while a result waits on result_out.
`timescale 1ns / 1ps

module text_console_writer (
  input  logic                            clk,
  input  logic                            rst,
  tcw_in_if.sink                          char_in,
  tcw_out_if.source                       result_out,
  input  logic                            cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r,
                                                  logic [COL_W-1:0] c,
                                                  logic [ROW_W-1:0] t);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(32'(s) * COLUMNS) + ADDR_W'(c);
  endfunction

  state_t state, state_next;

  logic [3:0]        fore_colour, back_colour;
  logic [ROW_W-1:0]  row_pos, row_next;
  logic [COL_W-1:0]  col_pos, col_next;
  logic [ROW_W-1:0]  top_row, top_next;
  logic [ADDR_W-1:0] sweep_cnt;
  logic [ADDR_W-1:0] blank_base;

  kind_t       it_kind;
  logic [7:0]  it_char;
  logic [3:0]  it_fore;
  logic [4:0]  it_read_row;
  logic [6:0]  it_read_col;

  logic [CELL_W-1:0] cell_res;
  logic              scr_res, scr_next;

  logic              out_valid;
  logic [4:0]        out_row;
  logic [6:0]        out_col;
  logic [CELL_W-1:0] out_cell;
  logic              out_scr;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic              is_nl, is_tab, is_bs, plain, do_write, do_line, read_ok;
  logic [COL_W:0]    col_sum;
  logic [COL_W-1:0]  wr_col;
  logic [3:0]        wr_fore;
  logic [7:0]        wr_char;
  logic              sweep_last, out_free;

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // character handling for plain and glyph words, and the range check for read words
  always_comb begin
    plain    = (it_kind == KIND_PLAIN);
    is_nl    = (it_char == CH_LF) || (it_char == CH_CR);
    is_tab   = plain && (it_char == CH_TAB);
    is_bs    = plain && (it_char == CH_BS);
    do_write = !is_nl && !is_tab;
    wr_fore  = plain ? fore_colour : it_fore;
    wr_char  = is_bs ? CH_SPACE : it_char;
    wr_col   = col_pos;
    col_sum  = {1'b0, col_pos} + (COL_W+1)'(1);
    do_line  = 1'b0;
    col_next = col_pos;
    if (is_nl) begin
      do_line = 1'b1;
    end else if (is_tab) begin
      col_sum = {1'b0, col_pos} + (COL_W+1)'(TAB_STEP);
      if (col_sum >= (COL_W+1)'(COLUMNS)) begin
        do_line = 1'b1;
      end else begin
        col_next = col_sum[COL_W-1:0];
      end
    end else if (is_bs) begin
      if (col_pos != '0) begin
        col_next = col_pos - COL_W'(1);
      end
      wr_col = col_next;
    end else begin
      if (col_sum >= (COL_W+1)'(COLUMNS)) begin
        do_line = 1'b1;
      end else begin
        col_next = col_sum[COL_W-1:0];
      end
    end
    row_next = row_pos;
    top_next = top_row;
    scr_next = 1'b0;
    if (do_line) begin
      col_next = '0;
      if (row_pos == ROW_W'(ROWS - 1)) begin
        scr_next = 1'b1;
        top_next = (top_row == ROW_W'(ROWS - 1)) ? '0 : top_row + ROW_W'(1);
      end else begin
        row_next = row_pos + ROW_W'(1);
      end
    end
    read_ok = (32'(it_read_row) < ROWS) && (32'(it_read_col) < COLUMNS);
  end

  assign out_free = !out_valid || result_out.ready;

  always_comb begin
    case (state)
      ST_INIT, ST_CLEAR: sweep_last = (sweep_cnt == ADDR_W'(DEPTH - 1));
      default:           sweep_last = (sweep_cnt == ADDR_W'(COLUMNS - 1));
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (char_in.valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (it_kind)
          KIND_CLEAR: state_next = ST_CLEAR;
          KIND_READ:  state_next = read_ok ? ST_READ : ST_DONE;
          default:    state_next = scr_next ? ST_BLANK : ST_DONE;
        endcase
      end
      ST_READ: state_next = ST_DONE;
      ST_BLANK, ST_CLEAR: begin
        if (sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // RAM and handshake outputs
  always_comb begin
    char_in.ready = (state == ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = make_cell(CH_SPACE, fore_colour, back_colour);
    ram_re    = 1'b0;
    ram_raddr = cell_addr(ROW_W'(it_read_row), COL_W'(it_read_col), top_row);
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt;
        ram_wdata = make_cell(CH_SPACE, RESET_FORE, RESET_BACK);
      end
      ST_EXEC: begin
        if (it_kind == KIND_READ) begin
          ram_re = read_ok;
        end else if (it_kind != KIND_CLEAR) begin
          ram_we    = do_write;
          ram_waddr = cell_addr(row_pos, wr_col, top_row);
          ram_wdata = make_cell(wr_char, wr_fore, back_colour);
        end
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = blank_base + sweep_cnt;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      fore_colour <= RESET_FORE;
      back_colour <= RESET_BACK;
      row_pos     <= '0;
      col_pos     <= '0;
      top_row     <= '0;
      sweep_cnt   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_FORE_COLOUR: fore_colour <= cfg_data[3:0];
          REG_BACK_COLOUR: back_colour <= cfg_data[3:0];
          default: ;
        endcase
      end
      case (state)
        ST_INIT, ST_BLANK, ST_CLEAR: begin
          sweep_cnt <= sweep_last ? '0 : sweep_cnt + ADDR_W'(1);
        end
        ST_EXEC: begin
          sweep_cnt <= '0;
          case (it_kind)
            KIND_CLEAR: begin
              row_pos <= '0;
              col_pos <= '0;
              top_row <= '0;
            end
            KIND_READ: ;
            default: begin
              row_pos <= row_next;
              col_pos <= col_next;
              top_row <= top_next;
            end
          endcase
        end
        default: ;
      endcase
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && char_in.valid) begin
      it_kind     <= char_in.kind;
      it_char     <= char_in.char_code;
      it_fore     <= char_in.char_fore;
      it_read_row <= char_in.read_row;
      it_read_col <= char_in.read_col;
    end
    if (state == ST_EXEC) begin
      cell_res   <= '0;
      scr_res    <= (it_kind == KIND_PLAIN || it_kind == KIND_GLYPH) && scr_next;
      blank_base <= ADDR_W'(32'(top_row) * COLUMNS);
    end
    if (state == ST_READ) begin
      cell_res <= ram_rdata;
    end
    if (state == ST_DONE && out_free) begin
      out_row  <= 5'(row_pos);
      out_col  <= 7'(col_pos);
      out_cell <= cell_res;
      out_scr  <= scr_res;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.cursor_row = out_row;
  assign result_out.cursor_col = out_col;
  assign result_out.cell_value = out_cell;
  assign result_out.scrolled   = out_scr;

endmodule
